// ===== rtl/arp_pkg.sv =====
// Shared types, codes and helpers of the held-pool arpeggiator.
`timescale 1ns / 1ps

package arp_pkg;

  localparam int KEY_W      = 7;
  localparam int NOTE_W     = 8;
  localparam int VEL_W      = 7;
  localparam int NOW_W      = 16;
  localparam int TICK_W     = 18;
  localparam int STEP_W     = 32;
  localparam int GATE_W     = 9;
  localparam int SPAN_W     = 4;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // remainder width: covers octave spans up to 15 and pool counts up to 16
  localparam int DIV_W      = 5;
  // remainder unit retires two dividend bits a cycle
  localparam int DIV_STEPS  = STEP_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int SEMIS_PER_OCT = 12;

  // input commands
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  // arpeggio modes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_UP    = 2'd1;
  localparam logic [1:0] MODE_CYCLE = 2'd2;

  // rate codes
  localparam logic [2:0] RATE_QUARTER   = 3'd0;
  localparam logic [2:0] RATE_EIGHTH    = 3'd1;
  localparam logic [2:0] RATE_SIXTEENTH = 3'd2;
  localparam logic [2:0] RATE_SIXT_TRIP = 3'd3;
  localparam logic [2:0] RATE_THIRTY2   = 3'd4;
  localparam logic [2:0] RATE_T32_TRIP  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ARP_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_CODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_Q8       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_SPAN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_VELOCITY = 3'd4;

  typedef struct packed {
    logic [1:0]        arp_mode;
    logic [2:0]        rate_code;
    logic [GATE_W-1:0] gate_q8;
    logic [SPAN_W-1:0] octave_span;
    logic [VEL_W-1:0]  note_velocity;
  } arp_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV,
    ST_NOTE_ON,
    ST_NOTE_OFF
  } arp_state_e;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic press;
    logic release_key;
    logic div_load;
    logic div_step;
    logic note_on;
    logic note_off;
  } arp_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             tick_go;
    logic             on_due;
    logic             off_due;
    logic             off_after_on;
  } arp_status_t;

  // one restoring remainder step: shift in a dividend bit, subtract if it fits
  function automatic logic [DIV_W-1:0] rem_step(input logic [DIV_W-1:0] rem,
                                                input logic             b,
                                                input logic [DIV_W-1:0] d);
    logic [DIV_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[DIV_W-1:0];
  endfunction

endpackage

// ===== rtl/arp_cfg_regs.sv =====
// Configuration register file of the arpeggiator.
`timescale 1ns / 1ps

module arp_cfg_regs
  import arp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output arp_cfg_t              cfg_o
);

  arp_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ARP_MODE:      cfg_d.arp_mode      = cfg_data_i[1:0];
        CFG_RATE_CODE:     cfg_d.rate_code     = cfg_data_i[2:0];
        CFG_GATE_Q8:       cfg_d.gate_q8       = cfg_data_i[GATE_W-1:0];
        CFG_OCTAVE_SPAN:   cfg_d.octave_span   = cfg_data_i[SPAN_W-1:0];
        CFG_NOTE_VELOCITY: cfg_d.note_velocity = cfg_data_i[VEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arp_mode      <= MODE_OFF;
      cfg_q.rate_code     <= RATE_SIXTEENTH;
      cfg_q.gate_q8       <= GATE_W'(205);
      cfg_q.octave_span   <= SPAN_W'(3);
      cfg_q.note_velocity <= VEL_W'(120);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/arp_ctrl.sv =====
// Sequencing state machine of the arpeggiator.
`timescale 1ns / 1ps

module arp_ctrl
  import arp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  arp_status_t status_i,
  output arp_ctl_t    ctl_o,
  output logic        busy_o
);

  arp_state_e           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        state_d = ST_IDLE;
        if (status_i.cmd == CMD_TICK && status_i.tick_go && status_i.on_due) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = ST_NOTE_ON;
      end
      ST_NOTE_ON: begin
        state_d = status_i.off_after_on ? ST_NOTE_OFF : ST_IDLE;
      end
      ST_NOTE_OFF: state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o = '0;
    unique case (state_q)
      ST_IDLE: ctl_o.latch = start_i;
      ST_DISPATCH: begin
        case (status_i.cmd)
          CMD_PRESS:   ctl_o.press       = 1'b1;
          CMD_RELEASE: ctl_o.release_key = 1'b1;
          CMD_TICK: begin
            if (status_i.tick_go) begin
              if (status_i.on_due)       ctl_o.div_load = 1'b1;
              else if (status_i.off_due) ctl_o.note_off = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_DIV:      ctl_o.div_step = 1'b1;
      ST_NOTE_ON:  ctl_o.note_on  = 1'b1;
      ST_NOTE_OFF: ctl_o.note_off = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== rtl/arp_datapath.sv =====
// Held pool, voice state, remainder unit and result register.
`timescale 1ns / 1ps

module arp_datapath
  import arp_pkg::*;
#(
  parameter int POOL_DEPTH        = 8,
  parameter int TICKS_PER_QUARTER = 96
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  arp_cfg_t          cfg_i,
  input  arp_ctl_t          ctl_i,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [KEY_W-1:0]  key_note_i,
  input  logic [NOW_W-1:0]  tick_now_i,
  output arp_status_t       status_o,
  output logic              out_valid_o,
  output logic [NOTE_W-1:0] out_note_o,
  output logic [VEL_W-1:0]  out_velocity_o,
  output logic              last_of_run_o
);

  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int IV_W  = $clog2(TICKS_PER_QUARTER + 1);
  localparam int PR_W  = IV_W + GATE_W;

  localparam int IvQuarter = TICKS_PER_QUARTER;
  localparam int IvEighth  = TICKS_PER_QUARTER / 2;
  localparam int IvSixt    = TICKS_PER_QUARTER / 4;
  localparam int IvSixtTr  = TICKS_PER_QUARTER / 6;
  localparam int IvThirty2 = TICKS_PER_QUARTER / 8;
  localparam int IvT32Tr   = TICKS_PER_QUARTER / 12;

  // held pool: entries at or above the count take no part in a lookup
  logic [KEY_W-1:0] pool_q [POOL_DEPTH];
  logic [KEY_W-1:0] pool_d [POOL_DEPTH];
  logic [KEY_W-1:0] pool_nx [POOL_DEPTH];

  logic [CNT_W-1:0]  count_q, count_d;
  logic              armed_q, armed_d;
  logic              sounding_q, sounding_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [TICK_W-1:0] due_q, due_d;
  logic [TICK_W-1:0] rel_q, rel_d;
  logic [NOTE_W-1:0] snote_q, snote_d;

  // latched beat
  logic [CMD_W-1:0]  cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [NOW_W-1:0]  now_q;

  // remainder unit
  logic [STEP_W-1:0] sh_q;
  logic [DIV_W-1:0]  rem_q;
  logic [DIV_W-1:0]  divisor;
  logic [DIV_W-1:0]  rem_mid;

  logic [PR_W-1:0]   prod_q;
  logic [IV_W-1:0]   iv;

  logic              out_valid_q, out_valid_d;
  logic [NOTE_W-1:0] out_note_q, out_note_d;
  logic [VEL_W-1:0]  out_vel_q, out_vel_d;
  logic              out_last_q, out_last_d;

  logic [POOL_DEPTH-1:0] match;
  logic [POOL_DEPTH-1:0] shift_en;
  logic                  hit, full, mode_on;
  logic [CNT_W-1:0]      count_rm;
  logic [TICK_W-1:0]     now_x, new_rel;
  logic [NOTE_W-1:0]     note_sel, oct_add;

  assign mode_on = (cfg_i.arp_mode == MODE_UP) || (cfg_i.arp_mode == MODE_CYCLE);
  assign now_x   = TICK_W'(now_q);

  always_comb begin
    unique case (cfg_i.rate_code)
      RATE_QUARTER:   iv = IV_W'(IvQuarter);
      RATE_EIGHTH:    iv = IV_W'(IvEighth);
      RATE_SIXT_TRIP: iv = IV_W'(IvSixtTr);
      RATE_THIRTY2:   iv = IV_W'(IvThirty2);
      RATE_T32_TRIP:  iv = IV_W'(IvT32Tr);
      default:        iv = IV_W'(IvSixt);
    endcase
  end

  // gate product; the user must keep the config steady while an item is in flight, the block does not enforce it
  always_ff @(posedge clk_i) begin
    prod_q <= PR_W'(iv) * PR_W'(cfg_i.gate_q8);
  end

  assign new_rel = now_x + TICK_W'(prod_q[PR_W-1:8]);

  // pool lookup
  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_match
    assign match[i] = (CNT_W'(i) < count_q) && (pool_q[i] == key_q);
    if (i < POOL_DEPTH - 1) begin : g_up
      assign pool_nx[i] = pool_q[i + 1];
    end else begin : g_top
      assign pool_nx[i] = pool_q[i];
    end
  end

  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int j = 0; j < POOL_DEPTH; j++) begin
      acc         = acc | match[j];
      shift_en[j] = acc;
    end
  end

  assign hit      = |match;
  assign full     = (count_q == CNT_W'(POOL_DEPTH));
  assign count_rm = hit ? count_q - 1'b1 : count_q;

  // remainder divisor: octave span (0 acts as 1) or pool size
  assign divisor = (cfg_i.arp_mode == MODE_UP) ?
                   ((cfg_i.octave_span == '0) ? DIV_W'(1) : DIV_W'(cfg_i.octave_span)) :
                   DIV_W'(count_q);
  assign rem_mid = rem_step(rem_q, sh_q[STEP_W-1], divisor);

  // octave offset = rem * 12
  assign oct_add  = NOTE_W'({rem_q, 3'b000}) + NOTE_W'({rem_q, 2'b00});
  assign note_sel = (cfg_i.arp_mode == MODE_UP) ?
                    NOTE_W'(pool_q[0]) + oct_add :
                    NOTE_W'(pool_q[rem_q[IDX_W-1:0]]);

  always_comb begin
    pool_d      = pool_q;
    count_d     = count_q;
    armed_d     = armed_q;
    sounding_d  = sounding_q;
    step_d      = step_q;
    due_d       = due_q;
    rel_d       = rel_q;
    snote_d     = snote_q;
    out_valid_d = 1'b0;
    out_note_d  = out_note_q;
    out_vel_d   = out_vel_q;
    out_last_d  = out_last_q;

    if (ctl_i.press && mode_on) begin
      if (!hit && !full) begin
        pool_d[count_q[IDX_W-1:0]] = key_q;
        count_d = count_q + 1'b1;
      end
      armed_d    = 1'b1;
      sounding_d = 1'b0;
      step_d     = '0;
      due_d      = now_x;
      rel_d      = '0;
    end

    if (ctl_i.release_key) begin
      for (int j = 0; j < POOL_DEPTH; j++) begin
        if (shift_en[j]) pool_d[j] = pool_nx[j];
      end
      count_d = count_rm;
      if (sounding_q && armed_q) begin
        out_valid_d = 1'b1;
        out_note_d  = snote_q;
        out_vel_d   = '0;
        out_last_d  = 1'b1;
        sounding_d  = 1'b0;
      end
      if (count_rm == '0) armed_d = 1'b0;
    end

    if (ctl_i.note_on) begin
      out_valid_d = 1'b1;
      out_note_d  = note_sel;
      out_vel_d   = cfg_i.note_velocity;
      out_last_d  = !(now_x >= new_rel);
      snote_d     = note_sel;
      sounding_d  = 1'b1;
      rel_d       = new_rel;
      due_d       = now_x + TICK_W'(iv);
      step_d      = step_q + 1'b1;
    end

    if (ctl_i.note_off) begin
      out_valid_d = 1'b1;
      out_note_d  = snote_q;
      out_vel_d   = '0;
      out_last_d  = 1'b1;
      sounding_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      armed_q     <= 1'b0;
      sounding_q  <= 1'b0;
      step_q      <= '0;
      due_q       <= '0;
      rel_q       <= '0;
      snote_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      armed_q     <= armed_d;
      sounding_q  <= sounding_d;
      step_q      <= step_d;
      due_q       <= due_d;
      rel_q       <= rel_d;
      snote_q     <= snote_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    pool_q     <= pool_d;
    out_note_q <= out_note_d;
    out_vel_q  <= out_vel_d;
    out_last_q <= out_last_d;
    if (ctl_i.latch) begin
      cmd_q <= cmd_i;
      key_q <= key_note_i;
      now_q <= tick_now_i;
    end
    if (ctl_i.div_load) begin
      sh_q  <= step_q;
      rem_q <= '0;
    end else if (ctl_i.div_step) begin
      sh_q  <= {sh_q[STEP_W-3:0], 2'b00};
      rem_q <= rem_step(rem_mid, sh_q[STEP_W-2], divisor);
    end
  end

  assign status_o.cmd          = cmd_q;
  assign status_o.tick_go      = armed_q && (count_q != '0) && mode_on;
  assign status_o.on_due       = !sounding_q && (now_x >= due_q);
  assign status_o.off_due      = sounding_q && (now_x >= rel_q);
  assign status_o.off_after_on = (now_x >= new_rel);

  assign out_valid_o    = out_valid_q;
  assign out_note_o     = out_note_q;
  assign out_velocity_o = out_vel_q;
  assign last_of_run_o  = out_last_q;

endmodule

// ===== rtl/arpeggiator_held_pool.sv =====
// Top level of the monophonic held-pool arpeggiator.
// Order: a release or note-off result is registered out of the dispatch state; a note-on
//   follows the remainder unit, and a same-tick note-off comes out in the next cycle.
// Busy: a beat is taken only while the block is idle, and a note-on tick also runs the
//   two-bits-a-cycle remainder unit before the block is idle again.
// Results go out as single-cycle strobes; the receiver cannot stall.
// Reset (rst_ni low, async) empties the pool, silences the voice, restores config defaults.
`timescale 1ns / 1ps

module arpeggiator_held_pool
  import arp_pkg::*;
#(
  parameter int POOL_DEPTH        = 8,
  parameter int TICKS_PER_QUARTER = 96
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command channel
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [KEY_W-1:0]      key_note_i,
  input  logic [NOW_W-1:0]      tick_now_i,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // result strobe
  output logic                  out_valid_o,
  output logic [NOTE_W-1:0]     out_note_o,
  output logic [VEL_W-1:0]      out_velocity_o,
  output logic                  last_of_run_o
);

  arp_cfg_t    cfg;
  arp_ctl_t    ctl;
  arp_status_t status;

  // register file: the user must write it only while the block is idle; the block does not enforce this
  arp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // controller: latch the beat, dispatch on the command, run the remainder
  // unit for note selection, then emit note-on and optional note-off
  arp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .ctl_o    (ctl),
    .busy_o   (busy_o)
  );

  // datapath: pool, voice timing, step remainder and output register
  arp_datapath #(
    .POOL_DEPTH        (POOL_DEPTH),
    .TICKS_PER_QUARTER (TICKS_PER_QUARTER)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .ctl_i          (ctl),
    .cmd_i          (cmd_i),
    .key_note_i     (key_note_i),
    .tick_now_i     (tick_now_i),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_note_o     (out_note_o),
    .out_velocity_o (out_velocity_o),
    .last_of_run_o  (last_of_run_o)
  );

  // an accepted beat always makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted beat did not start work");

  // every result comes out of work in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy_o))
    else $error("result strobe without preceding work");

  // a note-on that is not last is followed at once by its note-off
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_run_o) |=> (out_valid_o && last_of_run_o &&
                                         out_velocity_o == '0))
    else $error("note-off missing after non-final note-on");

  // the final result of a run is never directly followed by another
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_run_o) |=> !out_valid_o)
    else $error("result straight after end of run");

endmodule

// ===== tb/sv/arpeggiator_held_pool_tb.sv =====
// Self-checking testbench for the held-pool arpeggiator: stimulus, event predictor, checks.
`timescale 1ns / 1ps

module arpeggiator_held_pool_tb;
  import arp_pkg::*;

  localparam int TPQ          = 96;
  localparam int POOL_SLOTS   = 8;
  // a note-on beat takes the longest; leave margin on top
  localparam int QUIET_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_CAP    = 40;

  // codes the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_UNUSED    = 2'd3;
  localparam logic [1:0]       MODE_SPARE    = 2'd3;
  localparam logic [2:0]       RATE_SPARE_LO = 3'd6;
  localparam logic [2:0]       RATE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic              last;
  } arp_event_t;

  // Mirrors the arpeggiator: pool, voice and registers, plus the queue of
  // note events still owed by the block.
  class arp_event_board;
    logic [1:0]        mode;
    logic [2:0]        rate;
    logic [GATE_W-1:0] gate;
    logic [SPAN_W-1:0] span;
    logic [VEL_W-1:0]  vel;

    logic [KEY_W-1:0]  held_keys [POOL_SLOTS];
    int unsigned       held_total;
    bit                armed;
    bit                sounding;
    logic [STEP_W-1:0] steps;
    logic [TICK_W-1:0] due_at;
    logic [TICK_W-1:0] off_at;
    logic [NOTE_W-1:0] voiced_note;

    arp_event_t        pending_events [$];
    int                errors;

    function new();
      mode        = MODE_OFF;
      rate        = RATE_SIXTEENTH;
      gate        = GATE_W'(205);
      span        = SPAN_W'(3);
      vel         = VEL_W'(120);
      foreach (held_keys[i]) held_keys[i] = '0;
      held_total  = 0;
      armed       = 1'b0;
      sounding    = 1'b0;
      steps       = '0;
      due_at      = '0;
      off_at      = '0;
      voiced_note = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ARP_MODE:      mode = data[1:0];
        CFG_RATE_CODE:     rate = data[2:0];
        CFG_GATE_Q8:       gate = data[GATE_W-1:0];
        CFG_OCTAVE_SPAN:   span = data[SPAN_W-1:0];
        CFG_NOTE_VELOCITY: vel  = data[VEL_W-1:0];
        default: ;
      endcase
    endfunction

    // step length in ticks; spare rate codes fall back to a sixteenth
    function int unsigned interval();
      case (rate)
        RATE_QUARTER:   return TPQ;
        RATE_EIGHTH:    return TPQ / 2;
        RATE_SIXT_TRIP: return TPQ / 6;
        RATE_THIRTY2:   return TPQ / 8;
        RATE_T32_TRIP:  return TPQ / 12;
        default:        return TPQ / 4;
      endcase
    endfunction

    function void hold_key(logic [KEY_W-1:0] key);
      bit seen;
      seen = 1'b0;
      for (int i = 0; i < held_total; i++)
        if (held_keys[i] == key) seen = 1'b1;
      if (!seen && held_total < POOL_SLOTS) begin
        held_keys[held_total] = key;
        held_total++;
      end
    endfunction

    // drop the first match and close the gap behind it
    function void drop_key(logic [KEY_W-1:0] key);
      int hit;
      hit = -1;
      for (int i = 0; i < held_total; i++)
        if (hit < 0 && held_keys[i] == key) hit = i;
      if (hit >= 0) begin
        for (int j = hit; j + 1 < held_total; j++) held_keys[j] = held_keys[j + 1];
        held_total--;
      end
    endfunction

    // work out the events an accepted command beat owes and queue them
    function void note_beat(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                            logic [NOW_W-1:0] now);
      arp_event_t        owed [2];
      int                n;
      bit                running;
      int unsigned       iv;
      int unsigned       span_eff;
      logic [NOTE_W-1:0] pick;
      n       = 0;
      running = (mode == MODE_UP) || (mode == MODE_CYCLE);
      case (cmd)
        CMD_PRESS: begin
          if (running) begin
            hold_key(key);
            armed    = 1'b1;
            sounding = 1'b0;
            steps    = '0;
            due_at   = TICK_W'(now);
            off_at   = '0;
          end
        end
        CMD_RELEASE: begin
          drop_key(key);
          if (sounding && armed) begin
            owed[n] = '{voiced_note, VEL_W'(0), 1'b0};
            n++;
            sounding = 1'b0;
          end
          if (held_total == 0) armed = 1'b0;
        end
        CMD_TICK: begin
          if (armed && held_total != 0 && running) begin
            iv = interval();
            if (!sounding && TICK_W'(now) >= due_at) begin
              if (mode == MODE_UP) begin
                span_eff = (span == 0) ? 1 : span;
                pick = NOTE_W'(held_keys[0] + (steps % span_eff) * SEMIS_PER_OCT);
              end else begin
                pick = NOTE_W'(held_keys[steps % held_total]);
              end
              owed[n] = '{pick, vel, 1'b0};
              n++;
              voiced_note = pick;
              sounding    = 1'b1;
              off_at      = TICK_W'(now + ((iv * gate) >> 8));
              due_at      = TICK_W'(now + iv);
              steps++;
            end
            // short gates can end the note on the very tick that started it
            if (sounding && TICK_W'(now) >= off_at) begin
              owed[n] = '{voiced_note, VEL_W'(0), 1'b0};
              n++;
              sounding = 1'b0;
            end
          end
        end
        default: ;
      endcase
      if (n > 0) owed[n - 1].last = 1'b1;
      for (int k = 0; k < n; k++) pending_events.push_back(owed[k]);
    endfunction

    task report_mismatch(string what);
      if (errors < PRINT_CAP) $display("[%0t] MISMATCH %s", $realtime, what);
      errors++;
    endtask

    task check_beat(logic [NOTE_W-1:0] note, logic [VEL_W-1:0] velocity, logic last);
      arp_event_t want;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event note %0d vel %0d last %0d",
                                  note, velocity, last));
        return;
      end
      want = pending_events.pop_front();
      if (note !== want.note)
        report_mismatch($sformatf("note %0d, want %0d", note, want.note));
      if (velocity !== want.velocity)
        report_mismatch($sformatf("velocity %0d, want %0d (note %0d)",
                                  velocity, want.velocity, want.note));
      if (last !== want.last)
        report_mismatch($sformatf("last_of_run %0d, want %0d (note %0d)",
                                  last, want.last, want.note));
    endtask

    task check_leftover();
      if (pending_events.size() != 0)
        report_mismatch($sformatf("%0d events never came out", pending_events.size()));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Block I/O; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  start_i    = 1'b0;
  logic                  busy_o;
  logic [CMD_W-1:0]      cmd_i      = CMD_TICK;
  logic [KEY_W-1:0]      key_note_i = '0;
  logic [NOW_W-1:0]      tick_now_i = '0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = CFG_ARP_MODE;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  out_valid_o;
  logic [NOTE_W-1:0]     out_note_o;
  logic [VEL_W-1:0]      out_velocity_o;
  logic                  last_of_run_o;

  arp_event_board board;
  int               beats_sent = 0;  // accepted beats, unused commands not counted
  int               idle_pct   = 0;  // chance in 100 that the sender idles a cycle
  logic [NOW_W-1:0] playhead   = '0;
  int               cycle_count = 0;

  arpeggiator_held_pool #(
    .POOL_DEPTH        (POOL_SLOTS),
    .TICKS_PER_QUARTER (TPQ)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .key_note_i     (key_note_i),
    .tick_now_i     (tick_now_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_note_o     (out_note_o),
    .out_velocity_o (out_velocity_o),
    .last_of_run_o  (last_of_run_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result strobes last one cycle and cannot be held off: take each one at
  // the edge that closes its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) board.check_beat(out_note_o, out_velocity_o, last_of_run_o);
  end

  // Watchdog: a lost result or a stuck busy ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one command beat and hold it until the block takes it. With no
  // idling the next beat follows at once, so start stays high throughout.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [NOW_W-1:0] now);
    start_i    <= 1'b1;
    cmd_i      <= cmd;
    key_note_i <= key;
    tick_now_i <= now;
    do @(posedge clk_i); while (busy_o);
    board.note_beat(cmd, key, now);
    if (cmd != CMD_UNUSED) beats_sent++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Sender holds off until every owed event is out and the block is idle;
  // the tail covers beats that owe nothing but keep the block working.
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (board.pending_events.size() != 0 || busy_o);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  // only ever called with the block drained
  task automatic program_regs(input logic [1:0] mode, input logic [2:0] rate,
                              input int gate, input int span, input int vel);
    write_reg(CFG_ARP_MODE,      CFG_DATA_W'(mode));
    write_reg(CFG_RATE_CODE,     CFG_DATA_W'(rate));
    write_reg(CFG_GATE_Q8,       CFG_DATA_W'(gate));
    write_reg(CFG_OCTAVE_SPAN,   CFG_DATA_W'(span));
    write_reg(CFG_NOTE_VELOCITY, CFG_DATA_W'(vel));
    cfg_we_i <= 1'b0;
  endtask

  // A musical phrase: a chord goes down, the playhead runs on for a while
  // with the odd key change, then every key comes back up, ticks in between.
  task automatic play_phrase();
    logic [KEY_W-1:0] down [$];
    logic [KEY_W-1:0] k;
    int               presses;
    int               ticks;
    int               pick;
    int unsigned      hop;
    hop     = board.interval();
    // now and then enough keys to overflow the pool
    presses = ($urandom_range(9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 4);
    for (int i = 0; i < presses; i++) begin
      k = (down.size() != 0 && $urandom_range(5) == 0) ? down[0]
                                                         : KEY_W'($urandom_range(127));
      down.push_back(k);
      send_beat(CMD_PRESS, k, playhead);
    end
    ticks = $urandom_range(4, 24);
    for (int i = 0; i < ticks; i++) begin
      playhead += NOW_W'($urandom_range(0, hop));
      if ($urandom_range(11) == 0) begin
        if (down.size() > 1 && $urandom_range(1)) begin
          pick = $urandom_range(down.size() - 1);
          send_beat(CMD_RELEASE, down[pick], playhead);
          down.delete(pick);
        end else begin
          // press mid-phrase, often on a sounding voice
          k = KEY_W'($urandom_range(127));
          down.push_back(k);
          send_beat(CMD_PRESS, k, playhead);
        end
      end
      send_beat(CMD_TICK, KEY_W'($urandom_range(127)), playhead);
    end
    while (down.size() != 0) begin
      pick = $urandom_range(down.size() - 1);
      send_beat(CMD_RELEASE, down[pick], playhead);
      down.delete(pick);
      if ($urandom_range(1)) begin
        playhead += NOW_W'($urandom_range(0, hop));
        send_beat(CMD_TICK, KEY_W'($urandom_range(127)), playhead);
      end
    end
  endtask

  // One register setting, then random traffic: mostly phrases, some noise,
  // playhead jumps and stray releases or ticks that run backwards.
  task automatic run_phase(input logic [1:0] mode, input logic [2:0] rate, input int gate,
                           input int span, input int vel, input int pct, input int beats);
    int goal;
    int roll;
    drain_results();
    program_regs(mode, rate, gate, span, vel);
    idle_pct = pct;
    goal     = beats_sent + beats;
    while (beats_sent < goal) begin
      roll = $urandom_range(99);
      if (roll < 72) begin
        play_phrase();
      end else if (roll < 86) begin
        send_beat(CMD_W'($urandom_range(3)), KEY_W'($urandom_range(127)), NOW_W'($urandom()));
      end else if (roll < 92) begin
        // near the top the next due tick lands beyond 16 bits
        playhead = NOW_W'($urandom());
        if ($urandom_range(1)) playhead[15:8] = 8'hFF;
      end else begin
        send_beat(CMD_RELEASE, KEY_W'($urandom_range(127)), playhead);
        send_beat(CMD_TICK, KEY_W'($urandom_range(127)),
                  playhead - NOW_W'($urandom_range(1, 200)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    board = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // up-octave mode, sixteenths, zero gate, widest span, silent velocity
    program_regs(MODE_UP, RATE_SIXTEENTH, 0, 15, 0);
    send_beat(CMD_TICK, 7'd0, 16'd0);          // nothing armed yet
    send_beat(CMD_RELEASE, 7'd0, 16'd0);       // key never held, voice quiet
    send_beat(CMD_PRESS, 7'd127, 16'd10);
    send_beat(CMD_PRESS, 7'd127, 16'd10);      // duplicate: pool unchanged, re-arm
    send_beat(CMD_TICK, 7'd0, 16'd10);         // on and off in the same tick
    send_beat(CMD_TICK, 7'd0, 16'd34);         // next octave, note past 127
    send_beat(CMD_UNUSED, 7'd127, 16'hFFFF);   // ignored command
    for (int i = 0; i < 8; i++)
      send_beat(CMD_PRESS, KEY_W'(i), 16'd40); // fills the pool, last one dropped
    send_beat(CMD_TICK, 7'd0, 16'd40);

    // cycle mode, fastest rate, gate near two, loudest note
    drain_results();
    program_regs(MODE_CYCLE, RATE_T32_TRIP, 511, 1, 127);
    send_beat(CMD_TICK, 7'd0, 16'd100);        // note-on, off well after the next step
    send_beat(CMD_PRESS, 7'd64, 16'd100);      // full pool; silences with no note-off
    send_beat(CMD_TICK, 7'd0, 16'hFFFF);       // due tick moves past 16 bits
    send_beat(CMD_RELEASE, 7'd127, 16'hFFFF);  // sounding voice gets its note-off
    send_beat(CMD_TICK, 7'd0, 16'hFFFF);       // not due yet
    send_beat(CMD_RELEASE, 7'd100, 16'hFFFF);  // unheld key, voice quiet
    send_beat(CMD_PRESS, 7'd127, 16'hFFFF);
    send_beat(CMD_TICK, 7'd0, 16'hFFFF);

    // spare mode code acts as off, spare rate; release still ends the note
    drain_results();
    program_regs(MODE_SPARE, RATE_SPARE_HI, 128, 2, 60);
    send_beat(CMD_PRESS, 7'd5, 16'd0);
    send_beat(CMD_RELEASE, 7'd0, 16'd0);

    // random traffic across settings, extremes included
    run_phase(MODE_UP,     RATE_QUARTER,   256, 10, 127,  0, 230);
    run_phase(MODE_CYCLE,  RATE_T32_TRIP,    0,  1,   1, 84, 230);
    run_phase(MODE_CYCLE,  RATE_SPARE_LO,  511, 15,  64, 32, 230);
    run_phase(MODE_UP,     RATE_EIGHTH,    128,  0, 127,  0, 200);
    run_phase(MODE_CYCLE,  RATE_SIXT_TRIP, 205,  3, 120, 84, 230);
    run_phase(MODE_UP,     RATE_THIRTY2,   300,  7, 100, 32, 230);
    run_phase(MODE_SPARE,  RATE_SPARE_HI,    1,  2,  50,  0,  60);
    run_phase(MODE_OFF,    RATE_SIXTEENTH,  64,  4,  90, 32,  60);
    run_phase(MODE_UP,     RATE_SIXTEENTH,  96, 15, 127, 84, 230);

    drain_results();
    board.check_leftover();
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
